@@ rtl/core/iha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iha_pkg
// shared types and constants for the indexed handle array
// ----------------------------------------------------------------------------
package iha_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 32;

  // field widths of the stream words
  localparam int OP_W      = 3;
  localparam int IDX_W     = 7;
  localparam int HIN_W     = 32;
  localparam int ST_W      = 3;
  localparam int FILL_W    = 7;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 3'd0,
    OP_GET    = 3'd1,
    OP_PUSH   = 3'd2,
    OP_POP    = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_NULL      = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RFIRST,
    S_SHIFT,
    S_ZERO
  } state_e;

endpackage

@@ rtl/core/indexed_handle_array.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_handle_array
// fixed-capacity array of nonzero handles with fill count, kept in one
// synchronous memory, operated by set / get / push / pop / remove words
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (lsb first)                  | tuser
//  ---------+-----+------------------------------------+-----------
//  s_axis   | in  | index[6:0], handle_in[38:7], pad   | op[2:0]
//  m_axis   | out | handle_out[31:0], fill_count[38:32]| status[2:0]
//
//  ops: set, push, every error and a get past the fill count finish without
//  a memory read; get and pop make one memory read, as does a remove of the last
//  entry; any other remove moves each later entry down one slot, one entry per
//  cycle through the single read port and single write port of the slot memory
//  reset: every slot of the slot memory is swept to zero right after reset,
//  s_axis_tready stays low during the sweep
//  stalls: a finished word waits in the output register; a new word is taken
//  in idle as soon as that register is empty or being drained
// ----------------------------------------------------------------------------
module indexed_handle_array
  import iha_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // index[6:0], handle_in[38:7], zero pad
  input  logic [OP_W-1:0]      s_axis_tuser,   // op[2:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // handle_out[31:0], fill_count[38:32], pad
  output logic [ST_W-1:0]      m_axis_tuser    // status[2:0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // signed width that holds index, fill count and their sum
  localparam int RW = ((CW > IDX_W) ? CW : IDX_W) + 2;
  localparam logic signed [RW-1:0] DEPTH_S = RW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // slot memory, one write and one registered read per cycle
  logic [HANDLE_BITS-1:0] mem [DEPTH];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [HANDLE_BITS-1:0] mem_wd;
  logic                   mem_re;
  logic [AW-1:0]          mem_ra;
  logic [HANDLE_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // control and payload registers
  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [AW-1:0]          cur_q, cur_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [CW-1:0]          count_q, count_d;
  logic [HANDLE_BITS-1:0] hold_q, hold_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [HIN_W-1:0]       out_hout_q, out_hout_d;
  logic [FILL_W-1:0]      out_fill_q, out_fill_d;

  // input word unpacked
  logic                        acc;
  op_e                         op_in;
  logic signed [IDX_W-1:0]     idx_in;
  logic [HANDLE_BITS+HIN_W-1:0] h_wide;
  logic [HANDLE_BITS-1:0]      h_in;
  logic                        h_null;

  assign acc    = s_axis_tvalid && s_axis_tready;
  assign op_in  = op_e'(s_axis_tuser);
  assign idx_in = s_axis_tdata[IDX_W-1:0];
  assign h_wide = {{HANDLE_BITS{1'b0}}, s_axis_tdata[IDX_W+HIN_W-1:IDX_W]};
  assign h_in   = h_wide[HANDLE_BITS-1:0];
  assign h_null = (h_in == '0);

  // index resolution against the fill count
  logic signed [RW-1:0] n_s, idx_s, ridx_s;
  logic                 low_bad, in_n, in_depth;
  logic [AW-1:0]        ridx_a;
  logic [CW-1:0]        cnt_m1;

  assign n_s      = signed'({{(RW-CW){1'b0}}, count_q});
  assign idx_s    = signed'({{(RW-IDX_W){idx_in[IDX_W-1]}}, idx_in});
  assign low_bad  = idx_s < -n_s;
  assign ridx_s   = idx_s[RW-1] ? (n_s + idx_s) : idx_s;
  assign in_n     = ridx_s < n_s;
  assign in_depth = ridx_s < DEPTH_S;
  assign ridx_a   = ridx_s[AW-1:0];
  assign cnt_m1   = count_q - CW'(1);

  // decode of the word at the input
  status_e       dec_status;
  logic          dec_wr;
  logic          dec_rd;
  logic [AW-1:0] dec_addr;
  logic [CW-1:0] dec_cnt;

  always_comb begin
    dec_status = ST_OK;
    dec_wr     = 1'b0;
    dec_rd     = 1'b0;
    dec_addr   = ridx_a;
    dec_cnt    = count_q;
    case (op_in)
      OP_SET: begin
        if (low_bad) begin
          dec_status = ST_BAD_INDEX;
        end else if (h_null) begin
          dec_status = ST_NULL;
        end else if (!in_depth) begin
          dec_status = ST_BAD_INDEX;
        end else begin
          dec_wr = 1'b1;
          // gap slots past the fill count are already zero
          if (!in_n) begin
            dec_cnt = CW'(ridx_a) + CW'(1);
          end
        end
      end
      OP_GET: begin
        if (low_bad) begin
          dec_status = ST_BAD_INDEX;
        end else if (in_n) begin
          dec_rd = 1'b1;
        end
      end
      OP_PUSH: begin
        dec_addr = count_q[AW-1:0];
        if (h_null) begin
          dec_status = ST_NULL;
        end else if (count_q == CW'(DEPTH)) begin
          dec_status = ST_FULL;
        end else begin
          dec_wr  = 1'b1;
          dec_cnt = count_q + CW'(1);
        end
      end
      OP_POP: begin
        dec_addr = cnt_m1[AW-1:0];
        if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_rd = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (low_bad || !in_n) begin
          dec_status = ST_BAD_INDEX;
        end else begin
          dec_rd = 1'b1;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // remove walk helpers
  logic [CW-1:0] cur_p1;
  logic [CW:0]   cur_p2;
  logic          more_first;
  logic          more_shift;

  assign cur_p1     = CW'(cur_q) + CW'(1);
  assign cur_p2     = (CW+1)'(cur_q) + (CW+1)'(2);
  assign more_first = (op_q == OP_REMOVE) && (cur_p1 < count_q);
  assign more_shift = cur_p2 < (CW+1)'(count_q);

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc && dec_rd) begin
          state_d = S_RFIRST;
        end
      end
      S_RFIRST: begin
        state_d = more_first ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        if (!more_shift) begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and result
  logic                   out_load;
  status_e                res_status;
  logic [HANDLE_BITS-1:0] res_h;
  logic [CW-1:0]          res_cnt;
  logic [HANDLE_BITS+HIN_W-1:0] res_h_wide;
  logic [CW+FILL_W-1:0]   res_cnt_wide;

  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = cur_q;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = cur_q;
    op_d       = op_q;
    cur_d      = cur_q;
    clr_d      = clr_q;
    count_d    = count_q;
    hold_d     = hold_q;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_h      = '0;
    res_cnt    = count_q;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (acc) begin
          op_d  = op_in;
          cur_d = dec_addr;
          if (dec_wr) begin
            mem_we  = 1'b1;
            mem_wa  = dec_addr;
            mem_wd  = h_in;
            count_d = dec_cnt;
          end
          if (dec_rd) begin
            mem_re = 1'b1;
            mem_ra = dec_addr;
          end else begin
            out_load   = 1'b1;
            res_status = dec_status;
            res_cnt    = dec_cnt;
          end
        end
      end
      S_RFIRST: begin
        hold_d = rd_q;
        if (more_first) begin
          mem_re = 1'b1;
          mem_ra = cur_p1[AW-1:0];
        end else begin
          out_load = 1'b1;
          res_h    = rd_q;
          // pop, or remove of the last entry: clear the vacated slot
          if (op_q != OP_GET) begin
            mem_we  = 1'b1;
            mem_wa  = cnt_m1[AW-1:0];
            count_d = cnt_m1;
            res_cnt = cnt_m1;
          end
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = cur_q;
        mem_wd = rd_q;
        if (more_shift) begin
          mem_re = 1'b1;
          mem_ra = cur_p2[AW-1:0];
          cur_d  = cur_p1[AW-1:0];
        end
      end
      S_ZERO: begin
        mem_we   = 1'b1;
        mem_wa   = cnt_m1[AW-1:0];
        count_d  = cnt_m1;
        out_load = 1'b1;
        res_h    = hold_q;
        res_cnt  = cnt_m1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign res_h_wide   = {{HIN_W{1'b0}}, res_h};
  assign res_cnt_wide = {{FILL_W{1'b0}}, res_cnt};

  // output register, loaded only when empty or drained (see tready)
  always_comb begin
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_hout_d   = out_hout_q;
    out_fill_d   = out_fill_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_hout_d   = res_h_wide[HIN_W-1:0];
      out_fill_d   = res_cnt_wide[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    cur_q        <= cur_d;
    hold_q       <= hold_d;
    out_status_q <= out_status_d;
    out_hout_q   <= out_hout_d;
    out_fill_q   <= out_fill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W-HIN_W-FILL_W){1'b0}}, out_fill_q, out_hout_q};

endmodule

@@ rtl/core/iha_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iha_checker
// port-level checks for the indexed handle array
// ----------------------------------------------------------------------------
module iha_checker
  import iha_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [ST_W-1:0]      m_axis_tuser
);

  // memory sweep holds off input right after reset
  a_sweep_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during the clearing sweep");

  // an error word never carries a handle
  a_error_null_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == '0))
    else $error("handle on an error word");

  // full and empty match the reported fill count
  a_full_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser != ST_FULL) || (m_axis_tdata[38:32] == FILL_W'(DEPTH))) &&
      ((m_axis_tuser != ST_EMPTY) || (m_axis_tdata[38:32] == '0)))
    else $error("full or empty status disagrees with fill count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

endmodule

bind indexed_handle_array iha_checker #(.DEPTH(DEPTH)) u_iha_checker (.*);
